/* design/lfmr_pkg.sv */
package lfmr_pkg;

    // Ring geometry
    localparam int RING_BYTES   = 1024;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_MESSAGE  = 64;

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int FREE_W = $clog2(RING_BYTES + 1);
    localparam int LEN_W  = 7;
    localparam int HDR_W  = $clog2(HEADER_BYTES);

    // Input commands
    typedef enum logic [1:0] {
        OP_PUT_HDR  = 2'd0,
        OP_PUT_DATA = 2'd1,
        OP_GET      = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        RS_PUT_OK    = 2'd0,
        RS_PUT_FULL  = 2'd1,
        RS_DELIVERED = 2'd2,
        RS_EMPTY     = 2'd3
    } res_status_t;

    typedef struct packed {
        op_t              cmd;
        logic [LEN_W-1:0] msg_length;
        logic [31:0]      source_tag;
        logic [7:0]       data_byte;
    } in_item_t;

    typedef struct packed {
        res_status_t      status;
        logic [LEN_W-1:0] out_length;
        logic [31:0]      out_source;
        logic [7:0]       out_data;
        logic             data_valid;
        logic             last;
    } result_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_WR,
        S_HDR_RD,
        S_HDR_WAIT,
        S_GET_DEC,
        S_BODY
    } state_t;

    // Which result the datapath should drive
    typedef enum logic [2:0] {
        EM_NONE,
        EM_PUT_OK,
        EM_PUT_FULL,
        EM_EMPTY,
        EM_MSG0,
        EM_BYTE
    } emit_t;

    typedef struct packed {
        logic  load_put;
        logic  load_get;
        logic  hdr_wr;
        logic  put_end;
        logic  data_wr;
        logic  hdr_rd;
        logic  body_start;
        logic  body_rd;
        logic  get_end;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic put_refuse;
        logic data_ok;
        logic ring_empty;
        logic hdr_last;
        logic rd_valid;
        logic mlen_zero;
        logic issue_done;
        logic emit_last;
    } dp_stat_t;

    // Ring pointer increment with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_BYTES - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

/* design/length_framed_message_ring.sv */
// Channel   Direction  Handshake                         Payload
// command   in         start & !busy                     item   (in_item_t)
// result    out        result_strobe, one cycle, no wait result (result_t)
//
// Put data byte: busy stays low. Put header: the header bytes are written
// one per cycle through the single ring write port; a refused header or an
// empty-ring get is answered without leaving idle. Get: one ring read per
// cycle for the 8 header bytes and then each data byte.
// Reset clears pointers and control only; the ring needs no clearing pass.
// Results cannot be stalled: each appears for one cycle on result_strobe.
module length_framed_message_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lfmr_pkg::in_item_t item,
    output logic               result_strobe,
    output lfmr_pkg::result_t  result
);
    import lfmr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    lfmr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.cmd),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Ring, pointers and result register
    lfmr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .stat          (stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

/* design/lfmr_ctrl.sv */
module lfmr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lfmr_pkg::op_t     op,
    input  lfmr_pkg::dp_stat_t stat,
    output logic              busy,
    output lfmr_pkg::dp_cmd_t cmd
);
    import lfmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_PUT_HDR:
                        begin
                            if (!stat.put_refuse)
                                state_next = S_HDR_WR;
                        end
                        OP_GET:
                        begin
                            if (!stat.ring_empty)
                                state_next = S_HDR_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_HDR_WR:
            begin
                if (stat.hdr_last)
                    state_next = S_IDLE;
            end
            S_HDR_RD:
            begin
                if (stat.hdr_last)
                    state_next = S_HDR_WAIT;
            end
            S_HDR_WAIT: state_next = S_GET_DEC;
            S_GET_DEC:
            begin
                if (stat.mlen_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_BODY;
            end
            S_BODY:
            begin
                if (stat.rd_valid && stat.emit_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.emit = EM_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_PUT_HDR:
                        begin
                            cmd.load_put = 1'b1;
                            cmd.emit     = stat.put_refuse ? EM_PUT_FULL : EM_PUT_OK;
                        end
                        OP_PUT_DATA: cmd.data_wr = stat.data_ok;
                        OP_GET:
                        begin
                            if (stat.ring_empty)
                                cmd.emit = EM_EMPTY;
                            else
                                cmd.load_get = 1'b1;
                        end
                        default: cmd.emit = EM_NONE;
                    endcase
                end
            end
            S_HDR_WR:
            begin
                cmd.hdr_wr  = 1'b1;
                cmd.put_end = stat.hdr_last;
            end
            S_HDR_RD: cmd.hdr_rd = 1'b1;
            S_HDR_WAIT: cmd.emit = EM_NONE;
            S_GET_DEC:
            begin
                if (stat.mlen_zero)
                begin
                    cmd.emit    = EM_MSG0;
                    cmd.get_end = 1'b1;
                end
                else
                    cmd.body_start = 1'b1;
            end
            S_BODY:
            begin
                cmd.body_rd = !stat.issue_done;
                if (stat.rd_valid)
                begin
                    cmd.emit    = EM_BYTE;
                    cmd.get_end = stat.emit_last;
                end
            end
            default: cmd.emit = EM_NONE;
        endcase
    end

    // Once all body reads are out, the final byte must be landing now
    a_body_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BODY && stat.issue_done) |-> (stat.rd_valid && stat.emit_last))
        else $error("body read count and emit count out of step");

    // Read data only lands in read states
    a_rd_in_read_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.rd_valid |-> (state_reg == S_HDR_RD || state_reg == S_HDR_WAIT ||
                           state_reg == S_BODY))
        else $error("ring read data outside a get");

endmodule

/* design/lfmr_dp.sv */
module lfmr_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lfmr_pkg::in_item_t item,
    input  lfmr_pkg::dp_cmd_t  cmd,
    output lfmr_pkg::dp_stat_t stat,
    output logic               result_strobe,
    output lfmr_pkg::result_t  result
);
    import lfmr_pkg::*;

    // Ring memory
    logic [7:0] ring_mem [RING_BYTES];

    logic [PTR_W-1:0]  rp_reg, wp_reg, pend_reg, addr_reg;
    logic [LEN_W-1:0]  remaining_reg;
    logic              put_open_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [31:0]       src_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  emit_cnt_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_hdr_reg;
    logic [HDR_W-1:0]  rd_idx_reg;
    logic              strobe_reg;
    result_t           result_reg;
    result_t           result_next;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [7:0]        hdr_byte;
    logic [FREE_W-1:0] free_space;
    logic [FREE_W-1:0] need_space;
    logic [LEN_W-1:0]  len_clip;

    // Free space, taken as the full ring when pointers match
    always_comb
    begin
        if (rp_reg > wp_reg)
            free_space = FREE_W'(rp_reg) - FREE_W'(wp_reg);
        else
            free_space = FREE_W'(rp_reg) + FREE_W'(RING_BYTES) - FREE_W'(wp_reg);
        need_space = FREE_W'(item.msg_length) + FREE_W'(HEADER_BYTES);
    end

    // Status to the controller
    always_comb
    begin
        stat.put_refuse = (item.msg_length > LEN_W'(MAX_MESSAGE)) ||
                          (need_space >= free_space);
        stat.data_ok    = put_open_reg && (remaining_reg != '0);
        stat.ring_empty = (rp_reg == wp_reg);
        stat.hdr_last   = (cnt_reg == LEN_W'(HEADER_BYTES - 1));
        stat.rd_valid   = rd_valid_reg;
        stat.mlen_zero  = (len_reg == '0);
        stat.issue_done = (cnt_reg == len_reg);
        stat.emit_last  = (emit_cnt_reg == len_reg - 1'b1);
    end

    // Header byte layout: length, three zero bytes, source tag LSB first
    always_comb
    begin
        case (cnt_reg[HDR_W-1:0])
            3'd0:    hdr_byte = {1'b0, len_reg};
            3'd4:    hdr_byte = src_reg[7:0];
            3'd5:    hdr_byte = src_reg[15:8];
            3'd6:    hdr_byte = src_reg[23:16];
            3'd7:    hdr_byte = src_reg[31:24];
            default: hdr_byte = 8'd0;
        endcase
    end

    // Memory port selection
    always_comb
    begin
        mem_we    = cmd.hdr_wr || cmd.data_wr;
        mem_waddr = cmd.hdr_wr ? addr_reg : pend_reg;
        mem_wdata = cmd.hdr_wr ? hdr_byte : item.data_byte;
        mem_re    = cmd.hdr_rd || cmd.body_rd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= ring_mem[addr_reg];
    end

    // Stored length clipped to the largest message
    assign len_clip = (rd_data_reg[LEN_W-1:0] > LEN_W'(MAX_MESSAGE)) ?
                      LEN_W'(MAX_MESSAGE) : rd_data_reg[LEN_W-1:0];

    // Ring pointers and put state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            pend_reg      <= '0;
            remaining_reg <= '0;
            put_open_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= mem_re;
            strobe_reg   <= (cmd.emit != EM_NONE);
            if (cmd.load_put)
            begin
                put_open_reg  <= 1'b0;
                remaining_reg <= '0;
            end
            if (cmd.put_end)
            begin
                pend_reg <= ptr_inc(addr_reg);
                if (len_reg == '0)
                    wp_reg <= ptr_inc(addr_reg);
                else
                begin
                    put_open_reg  <= 1'b1;
                    remaining_reg <= len_reg;
                end
            end
            if (cmd.data_wr)
            begin
                pend_reg      <= ptr_inc(pend_reg);
                remaining_reg <= remaining_reg - 1'b1;
                if (remaining_reg == LEN_W'(1))
                begin
                    wp_reg       <= ptr_inc(pend_reg);
                    put_open_reg <= 1'b0;
                end
            end
            if (cmd.get_end)
                rp_reg <= addr_reg;
        end
    end

    // Per-transaction working registers
    always_ff @(posedge clk)
    begin
        rd_hdr_reg <= cmd.hdr_rd;
        rd_idx_reg <= cnt_reg[HDR_W-1:0];
        if (cmd.load_put)
        begin
            len_reg  <= item.msg_length;
            src_reg  <= item.source_tag;
            addr_reg <= wp_reg;
            cnt_reg  <= '0;
        end
        if (cmd.load_get)
        begin
            addr_reg <= rp_reg;
            cnt_reg  <= '0;
        end
        if (cmd.hdr_wr || mem_re)
        begin
            addr_reg <= ptr_inc(addr_reg);
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.body_start)
        begin
            cnt_reg      <= '0;
            emit_cnt_reg <= '0;
        end
        if (cmd.emit == EM_BYTE)
            emit_cnt_reg <= emit_cnt_reg + 1'b1;
        // Header fields captured as reads land
        if (rd_valid_reg && rd_hdr_reg)
        begin
            case (rd_idx_reg)
                3'd0:    len_reg        <= len_clip;
                3'd4:    src_reg[7:0]   <= rd_data_reg;
                3'd5:    src_reg[15:8]  <= rd_data_reg;
                3'd6:    src_reg[23:16] <= rd_data_reg;
                3'd7:    src_reg[31:24] <= rd_data_reg;
                default: src_reg        <= src_reg;
            endcase
        end
        result_reg <= result_next;
    end

    // Result formatting
    always_comb
    begin
        result_next        = '0;
        result_next.status = RS_PUT_OK;
        result_next.last   = 1'b1;
        case (cmd.emit)
            EM_PUT_FULL: result_next.status = RS_PUT_FULL;
            EM_EMPTY:    result_next.status = RS_EMPTY;
            EM_MSG0:
            begin
                result_next.status     = RS_DELIVERED;
                result_next.out_source = src_reg;
            end
            EM_BYTE:
            begin
                result_next.status     = RS_DELIVERED;
                result_next.out_length = len_reg;
                result_next.out_source = src_reg;
                result_next.out_data   = rd_data_reg;
                result_next.data_valid = 1'b1;
                result_next.last       = stat.emit_last;
            end
            default: result_next.status = RS_PUT_OK;
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // An open put always has bytes outstanding, and only then
    a_open_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        put_open_reg == (remaining_reg != '0))
        else $error("put_open and byte count disagree");

endmodule
